// ===== rtl/per_destination_arf_rate_select_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the per-destination rate selector
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PER_DESTINATION_ARF_RATE_SELECT_MACROS_SVH
`define PER_DESTINATION_ARF_RATE_SELECT_MACROS_SVH

// Same-cycle implication.
`define ARF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rate selector assertion failed");

// Next-cycle implication.
`define ARF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rate selector assertion failed");

`endif

// ===== rtl/arfrs_pkg.sv =====
// ----------------------------------------------------------------------------
// arfrs_pkg
// Shared word types, token control struct and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package arfrs_pkg;

    localparam logic [1:0] CFG_UP_THRESHOLD     = 2'd0;
    localparam logic [1:0] CFG_DOWN_THRESHOLD   = 2'd1;
    localparam logic [1:0] CFG_FALLBACK_RETRIES = 2'd2;
    localparam logic [1:0] CFG_RATES_IN_USE     = 2'd3;

    localparam int CFG_DATA_W = 8;

    typedef struct packed {
        logic        req_type;
        logic [47:0] dest_address;
        logic        acked;
        logic        min_rate_frame;
        logic [2:0]  stages_used;
    } req_word_t;

    typedef struct packed {
        logic [2:0] rate_index;
        logic [2:0] fallback_rate_index;
        logic [3:0] fallback_tries;
        logic [3:0] slot;
        logic       new_entry;
    } rsp_word_t;

    // Control part of the token that walks the cell row.
    typedef struct packed {
        logic vld;
        logic is_status;
        logic acked;
        logic min_rate;
        logic first;
        logic hit;
    } tok_ctl_t;

    typedef struct packed {
        logic [7:0] up_thr;
        logic [7:0] down_thr;
    } thr_t;

endpackage

`default_nettype wire

// ===== rtl/arfrs_cell.sv =====
// ----------------------------------------------------------------------------
// arfrs_cell
// One destination slot: address, rate and per-rate counters. The token is
// registered and handed to the next cell every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module arfrs_cell
    import arfrs_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int SLOT_W     = 4,
    parameter int RATES      = 8,
    parameter int RATE_W     = 3,
    parameter int COUNT_BITS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire thr_t              thr,
    input  wire logic [RATE_W-1:0] top_rate,
    input  wire logic              alloc_en,
    input  wire logic [SLOT_W-1:0] alloc_slot,
    input  wire logic [47:0]       alloc_addr,
    input  wire tok_ctl_t          ctl_in,
    input  wire logic [47:0]       addr_in,
    input  wire logic [SLOT_W-1:0] target_in,
    input  wire logic [SLOT_W-1:0] slot_in,
    input  wire logic [RATE_W-1:0] hrate_in,
    input  wire logic [RATE_W-1:0] trate_in,
    output tok_ctl_t               ctl_out,
    output logic [47:0]            addr_out,
    output logic [SLOT_W-1:0]      target_out,
    output logic [SLOT_W-1:0]      slot_out,
    output logic [RATE_W-1:0]      hrate_out,
    output logic [RATE_W-1:0]      trate_out
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SLOT_W-1:0]     MY_IDX  = SLOT_W'(IDX);

    logic [47:0]           addr_reg;
    logic                  valid_reg;
    logic [RATE_W-1:0]     rate_reg, rate_next;
    logic [COUNT_BITS-1:0] sc_reg [RATES];
    logic [COUNT_BITS-1:0] fc_reg [RATES];

    tok_ctl_t          ctl_reg, ctl_next;
    logic [47:0]       addr_tok_reg;
    logic [SLOT_W-1:0] target_reg, slot_reg, slot_next;
    logic [RATE_W-1:0] hrate_reg, hrate_next, trate_reg, trate_next;

    logic                  is_target, upd, go_up;
    logic [COUNT_BITS-1:0] sc_cur, fc_cur, sc_next, fc_next, preset;
    logic [7:0]            pre_raw;

    assign is_target = (target_in == MY_IDX);
    assign upd = ctl_in.vld && ctl_in.is_status && !ctl_in.min_rate && is_target;
    assign sc_cur = sc_reg[rate_reg];
    assign fc_cur = fc_reg[rate_reg];

    // Counter update of the current rate, then the step decisions.
    always_comb
    begin
        sc_next = sc_cur;
        fc_next = fc_cur;
        rate_next = rate_reg;
        go_up = 1'b0;
        if (!ctl_in.first)
        begin
            if (rate_reg != '0)
            begin
                sc_next = '0;
                fc_next = (fc_cur == CNT_MAX) ? fc_cur : fc_cur + 1'b1;
            end
            else
            begin
                sc_next = COUNT_BITS'(ctl_in.acked);
            end
        end
        else
        begin
            sc_next = (sc_cur == CNT_MAX) ? sc_cur : sc_cur + 1'b1;
            fc_next = '0;
        end
        if (!ctl_in.first && (32'(fc_next) >= 32'(thr.down_thr)))
        begin
            fc_next = '0;
            if (rate_reg != '0)
            begin
                rate_next = rate_reg - 1'b1;
            end
        end
        if (ctl_in.first && (32'(sc_next) >= 32'(thr.up_thr)))
        begin
            sc_next = '0;
            if (rate_reg < top_rate)
            begin
                rate_next = rate_reg + 1'b1;
                go_up = 1'b1;
            end
        end
    end

    // Failure preset for the new rate after a step up, floored and clipped.
    always_comb
    begin
        pre_raw = (thr.down_thr == 8'd0) ? 8'd0 : thr.down_thr - 8'd1;
        if (32'(pre_raw) > 32'(CNT_MAX))
        begin
            preset = CNT_MAX;
        end
        else
        begin
            preset = COUNT_BITS'(pre_raw);
        end
    end

    // Token handling as it passes this cell.
    always_comb
    begin
        ctl_next = ctl_in;
        slot_next = slot_in;
        hrate_next = hrate_in;
        trate_next = trate_in;
        if (ctl_in.vld)
        begin
            if (!ctl_in.is_status)
            begin
                if (!ctl_in.hit && valid_reg && (addr_reg == addr_in))
                begin
                    ctl_next.hit = 1'b1;
                    slot_next = MY_IDX;
                    hrate_next = rate_reg;
                end
                if (is_target)
                begin
                    trate_next = rate_reg;
                end
            end
            else if (is_target)
            begin
                trate_next = upd ? rate_next : rate_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rate_reg <= '0;
            ctl_reg <= '0;
            for (int r = 0; r < RATES; r++)
            begin
                sc_reg[r] <= '0;
                fc_reg[r] <= '0;
            end
        end
        else
        begin
            ctl_reg <= ctl_next;
            if (alloc_en && (alloc_slot == MY_IDX))
            begin
                valid_reg <= 1'b1;
            end
            if (upd)
            begin
                rate_reg <= rate_next;
                sc_reg[rate_reg] <= sc_next;
                fc_reg[rate_reg] <= fc_next;
                if (go_up)
                begin
                    fc_reg[rate_next] <= preset;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc_en && (alloc_slot == MY_IDX))
        begin
            addr_reg <= alloc_addr;
        end
        addr_tok_reg <= addr_in;
        target_reg <= target_in;
        slot_reg <= slot_next;
        hrate_reg <= hrate_next;
        trate_reg <= trate_next;
    end

    assign ctl_out = ctl_reg;
    assign addr_out = addr_tok_reg;
    assign target_out = target_reg;
    assign slot_out = slot_reg;
    assign hrate_out = hrate_reg;
    assign trate_out = trate_reg;

endmodule

`default_nettype wire

// ===== rtl/per_destination_arf_rate_select.sv =====
// ----------------------------------------------------------------------------
// per_destination_arf_rate_select
// Auto rate fallback kept per destination in a row of slot cells.
// ----------------------------------------------------------------------------
// The token is registered by each cell of the row in turn, then the result
// word is registered in the output stage, where it is offered to the receiver.
// One word is in the row at a time: the next word is taken only once the last
// result has reached the output register, which a stalled receiver can delay.
// A finished result may wait in the output stage while the next word is taken.
// Reset clears slot valid bits, rates, counters and both slot pointers, and
// loads the registers with 10, 2, 7 and 8. Addresses are written on use only.
`default_nettype none

module per_destination_arf_rate_select
    import arfrs_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int RATES      = 8,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire req_word_t             req_word,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output rsp_word_t                  rsp_word
);

`include "per_destination_arf_rate_select_macros.svh"

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RATE_W = $clog2(RATES);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    // Configuration registers.
    logic [7:0] up_thr_reg;
    logic [7:0] down_thr_reg;
    logic [3:0] fb_retries_reg;
    logic [3:0] rates_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_thr_reg <= 8'd10;
            down_thr_reg <= 8'd2;
            fb_retries_reg <= 4'd7;
            rates_in_use_reg <= 4'd8;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_UP_THRESHOLD:     up_thr_reg <= cfg_data;
                CFG_DOWN_THRESHOLD:   down_thr_reg <= cfg_data;
                CFG_FALLBACK_RETRIES: fb_retries_reg <= cfg_data[3:0];
                CFG_RATES_IN_USE:     rates_in_use_reg <= cfg_data[3:0];
            endcase
        end
    end

    // Highest usable rate: the rate count is clamped to one..RATES first.
    int unsigned       rates_eff;
    logic [RATE_W-1:0] top_rate;
    thr_t              thr;

    always_comb
    begin
        rates_eff = 32'(rates_in_use_reg);
        if (rates_eff < 1)
        begin
            rates_eff = 1;
        end
        if (rates_eff > RATES)
        begin
            rates_eff = RATES;
        end
        top_rate = RATE_W'(rates_eff - 1);
    end

    assign thr.up_thr = up_thr_reg;
    assign thr.down_thr = down_thr_reg;

    // Slot pointers and handshake state.
    logic [SLOT_W-1:0] repl_ptr_reg, repl_ptr_next;
    logic [SLOT_W-1:0] active_reg, active_next;
    logic              busy_reg, busy_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_word_t         rsp_word_reg, rsp_word_next;
    logic              hold_valid_reg, hold_valid_next;
    rsp_word_t         hold_word_reg, hold_word_next;

    // The token. Index 0 is the entry, index SLOTS the end of the row.
    tok_ctl_t          ctl_w    [SLOTS+1];
    logic [47:0]       addr_w   [SLOTS+1];
    logic [SLOT_W-1:0] target_w [SLOTS+1];
    logic [SLOT_W-1:0] slot_w   [SLOTS+1];
    logic [RATE_W-1:0] hrate_w  [SLOTS+1];
    logic [RATE_W-1:0] trate_w  [SLOTS+1];
    logic [SLOTS-1:0]  chain_vld;

    logic req_accept;

    assign req_stall = busy_reg;
    assign req_accept = req_valid && !busy_reg;

    // A status word targets the active slot; a request carries the replace
    // pointer so the victim cell can report its rate on a miss.
    always_comb
    begin
        ctl_w[0].vld = req_accept;
        ctl_w[0].is_status = req_word.req_type;
        ctl_w[0].acked = req_word.acked;
        ctl_w[0].min_rate = req_word.min_rate_frame;
        ctl_w[0].first = (req_word.stages_used == 3'd1);
        ctl_w[0].hit = 1'b0;
        addr_w[0] = req_word.dest_address;
        target_w[0] = req_word.req_type ? active_reg : repl_ptr_reg;
        slot_w[0] = '0;
        hrate_w[0] = '0;
        trate_w[0] = '0;
    end

    logic              alloc_en;
    logic              fin;
    tok_ctl_t          end_ctl;
    logic [SLOT_W-1:0] res_slot;
    logic [RATE_W-1:0] res_rate;
    logic [31:0]       res_slot_wide;
    logic [31:0]       res_rate_wide;
    rsp_word_t         res_word;

    assign end_ctl = ctl_w[SLOTS];
    assign fin = end_ctl.vld;
    assign alloc_en = fin && !end_ctl.is_status && !end_ctl.hit;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            arfrs_cell #(
                .IDX        (g),
                .SLOT_W     (SLOT_W),
                .RATES      (RATES),
                .RATE_W     (RATE_W),
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .thr        (thr),
                .top_rate   (top_rate),
                .alloc_en   (alloc_en),
                .alloc_slot (target_w[SLOTS]),
                .alloc_addr (addr_w[SLOTS]),
                .ctl_in     (ctl_w[g]),
                .addr_in    (addr_w[g]),
                .target_in  (target_w[g]),
                .slot_in    (slot_w[g]),
                .hrate_in   (hrate_w[g]),
                .trate_in   (trate_w[g]),
                .ctl_out    (ctl_w[g+1]),
                .addr_out   (addr_w[g+1]),
                .target_out (target_w[g+1]),
                .slot_out   (slot_w[g+1]),
                .hrate_out  (hrate_w[g+1]),
                .trate_out  (trate_w[g+1])
            );
            assign chain_vld[g] = ctl_w[g+1].vld;
        end
    endgenerate

    // Result of the token at the end of the row. A hit names the matching
    // slot; a miss or a status word names the target slot.
    always_comb
    begin
        if (!end_ctl.is_status && end_ctl.hit)
        begin
            res_slot = slot_w[SLOTS];
            res_rate = hrate_w[SLOTS];
        end
        else
        begin
            res_slot = target_w[SLOTS];
            res_rate = trate_w[SLOTS];
        end
        res_slot_wide = 32'(res_slot);
        res_rate_wide = 32'(res_rate);
        res_word.rate_index = res_rate_wide[2:0];
        res_word.fallback_rate_index = 3'd0;
        res_word.fallback_tries = fb_retries_reg;
        res_word.slot = res_slot_wide[3:0];
        res_word.new_entry = alloc_en;
    end

    always_comb
    begin
        repl_ptr_next = repl_ptr_reg;
        active_next = active_reg;
        if (alloc_en)
        begin
            repl_ptr_next = (target_w[SLOTS] == LAST_SLOT) ? '0
                                                           : target_w[SLOTS] + 1'b1;
        end
        if (fin && !end_ctl.is_status)
        begin
            active_next = res_slot;
        end
    end

    // Output stage with one holding word behind it. The row stays busy until
    // its result has reached the output register.
    logic rsp_free;

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        busy_next = busy_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next = rsp_word_reg;
        hold_valid_next = hold_valid_reg;
        hold_word_next = hold_word_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (req_accept)
        begin
            busy_next = 1'b1;
        end
        if (hold_valid_reg && rsp_free)
        begin
            rsp_valid_next = 1'b1;
            rsp_word_next = hold_word_reg;
            hold_valid_next = 1'b0;
            busy_next = 1'b0;
        end
        else if (fin)
        begin
            if (rsp_free)
            begin
                rsp_valid_next = 1'b1;
                rsp_word_next = res_word;
                busy_next = 1'b0;
            end
            else
            begin
                hold_valid_next = 1'b1;
                hold_word_next = res_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_ptr_reg <= '0;
            active_reg <= '0;
            busy_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            repl_ptr_reg <= repl_ptr_next;
            active_reg <= active_next;
            busy_reg <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
        hold_word_reg <= hold_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word = rsp_word_reg;

    // At most one token is in the row, and only while the block is busy.
    `ARF_ASSERT_IMPL(a_one_token, 1'b1, $onehot0(chain_vld))
    `ARF_ASSERT_IMPL(a_idle_row_empty, !busy_reg, chain_vld == '0)
    // A held word always sits behind a full output register.
    `ARF_ASSERT_IMPL(a_hold_behind_out, hold_valid_reg, rsp_valid_reg)
    // A result that cannot leave goes to the holding word.
    `ARF_ASSERT_NEXT(a_blocked_to_hold, fin && !rsp_free, hold_valid_reg && busy_reg)

endmodule

`default_nettype wire

// ===== dv/per_destination_arf_rate_select_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_destination_arf_rate_select_test
// Self-checking bench for the per-destination auto rate fallback selector.
// A directed walk covers the reset state, the address extremes, both kinds of
// word and the special status reports. Random phases then follow, each with
// its own register setting and idle mix. A local score model predicts every
// answer word, and the answer words are compared field by field in order.
// ----------------------------------------------------------------------------

module per_destination_arf_rate_select_test;
    import arfrs_pkg::*;

    // Geometry of the block as instantiated here (the RTL defaults).
    localparam int NSLOT   = 16;
    localparam int NRATE   = 8;
    localparam int CNT_MAX = 255;

    // Word kinds and the one stage count that means "first attempt made it".
    localparam logic       KIND_RATE_REQ    = 1'b0;
    localparam logic       KIND_TX_STATUS   = 1'b1;
    localparam logic [2:0] FIRST_STAGE_ONLY = 3'd1;

    // Register values the block holds after reset.
    localparam logic [7:0] RST_UP_THR  = 8'd10;
    localparam logic [7:0] RST_DOWN_THR = 8'd2;
    localparam logic [3:0] RST_RETRIES = 4'd7;
    localparam logic [3:0] RST_RATES   = 4'd8;

    // Random part: six phases, each with one register setting and idle mix.
    // The settings walk the extremes: a rise on every success, thresholds of
    // zero, no fallback retries, rate counts of zero and of 15 (above the top),
    // and the largest thresholds.
    localparam int NPHASE      = 6;
    localparam int PHASE_WORDS = 210;
    localparam int DEST_POOL   = 20;

    logic [7:0] up_set      [NPHASE] = '{8'd10, 8'd1,  8'd4, 8'd0,  8'd2, 8'd255};
    logic [7:0] down_set    [NPHASE] = '{8'd2,  8'd1,  8'd5, 8'd0,  8'd3, 8'd255};
    logic [7:0] retries_set [NPHASE] = '{8'd7,  8'd15, 8'd3, 8'd0,  8'd9, 8'd1};
    logic [7:0] rates_set   [NPHASE] = '{8'd8,  8'd8,  8'd4, 8'd15, 8'd0, 8'd1};
    int         send_idle_set [NPHASE] = '{0, 74, 0,  20, 0, 74};
    int         stall_set     [NPHASE] = '{0, 0,  74, 20, 0, 0};

    // ------------------------------------------------------------------------
    // Block hookup. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [1:0]            cfg_index = CFG_UP_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_word_t             req_word  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_word_t             rsp_word;

    per_destination_arf_rate_select u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Score model: a private copy of the table, the per-slot rates, the
    // counters and the registers. It advances once per accepted word, in the
    // order the block accepts them.
    // ------------------------------------------------------------------------
    logic [7:0]  up_thr;
    logic [7:0]  down_thr;
    logic [3:0]  retries;
    logic [3:0]  rates_used;
    logic [47:0] addr_tab  [NSLOT];
    bit          slot_vld  [NSLOT];
    logic [3:0]  repl_ptr;
    logic [3:0]  act_slot;
    logic [2:0]  rate_of   [NSLOT];
    int unsigned succ_cnt  [NRATE][NSLOT];
    int unsigned fail_cnt  [NRATE][NSLOT];

    // Answers still owed by the block, oldest first.
    rsp_word_t   owed_answers[$];

    // Bookkeeping for the closing summary.
    int error_count;
    int n_req;
    int n_status;
    int n_alloc;
    int n_rises;
    int n_drops;
    int n_checked;

    int send_idle_pct;
    int stall_pct;

    logic [47:0] dest_pool [DEST_POOL];

    function automatic void reset_score_model();
        up_thr     = RST_UP_THR;
        down_thr   = RST_DOWN_THR;
        retries    = RST_RETRIES;
        rates_used = RST_RATES;
        repl_ptr   = '0;
        act_slot   = '0;
        for (int s = 0; s < NSLOT; s++)
        begin
            addr_tab[s] = '0;
            slot_vld[s] = 1'b0;
            rate_of[s]  = '0;
            for (int r = 0; r < NRATE; r++)
            begin
                succ_cnt[r][s] = 0;
                fail_cnt[r][s] = 0;
            end
        end
    endfunction

    // Highest usable rate. A count of zero behaves as one, and counts beyond
    // the number of built-in rates are clipped.
    function automatic int unsigned rate_ceiling();
        int unsigned n;
        n = rates_used;
        if (n < 1)
            n = 1;
        if (n > NRATE)
            n = NRATE;
        return n - 1;
    endfunction

    // Scores one transmit report against the slot's current rate.
    function automatic void score_tx_status(logic [3:0] s, logic acked, logic [2:0] stages);
        int unsigned cur;
        int unsigned preset;
        bit          first_try;
        first_try = (stages == FIRST_STAGE_ONLY);
        cur       = rate_of[s];
        if (!first_try)
        begin
            // At the lowest rate a failure is not counted; only the success
            // counter follows the ack.
            if (cur != 0)
            begin
                succ_cnt[cur][s] = 0;
                if (fail_cnt[cur][s] < CNT_MAX)
                    fail_cnt[cur][s]++;
            end
            else
                succ_cnt[cur][s] = acked ? 1 : 0;
            if (fail_cnt[cur][s] >= down_thr)
            begin
                fail_cnt[cur][s] = 0;
                if (cur > 0)
                begin
                    rate_of[s] = 3'(cur - 1);
                    n_drops++;
                end
            end
        end
        else
        begin
            if (succ_cnt[cur][s] < CNT_MAX)
                succ_cnt[cur][s]++;
            fail_cnt[cur][s] = 0;
            if (succ_cnt[cur][s] >= up_thr)
            begin
                succ_cnt[cur][s] = 0;
                // A rate above the ceiling (left over from a larger rate
                // count) stays where it is until failures pull it down.
                if (cur < rate_ceiling())
                begin
                    // The new rate starts one failure short of dropping back.
                    preset = (down_thr > 0) ? down_thr - 1 : 0;
                    rate_of[s] = 3'(cur + 1);
                    fail_cnt[cur + 1][s] = preset;
                    n_rises++;
                end
            end
        end
    endfunction

    // Works out the answer word for one accepted word and advances the model.
    function automatic rsp_word_t next_rate_answer(req_word_t w);
        rsp_word_t  r;
        logic [3:0] s;
        bit         hit;
        bit         fresh;
        int         i;
        hit   = 1'b0;
        fresh = 1'b0;
        s     = '0;
        if (w.req_type == KIND_RATE_REQ)
        begin
            n_req++;
            // Only valid slots take part, and the lowest match wins.
            for (i = 0; i < NSLOT; i++)
            begin
                if (!hit && slot_vld[i] && addr_tab[i] == w.dest_address)
                begin
                    s   = 4'(i);
                    hit = 1'b1;
                end
            end
            // On a miss the round-robin slot is taken over, whoever owned it.
            // Its rate and counters carry over from the previous owner.
            if (!hit)
            begin
                s           = repl_ptr;
                addr_tab[s] = w.dest_address;
                slot_vld[s] = 1'b1;
                repl_ptr    = 4'((int'(s) + 1) % NSLOT);
                fresh       = 1'b1;
                n_alloc++;
            end
            act_slot = s;
        end
        else
        begin
            n_status++;
            // A report always refers to the last requested slot (slot 0 before
            // any request). Frames sent at the minimum rate leave no trace.
            s = act_slot;
            if (!w.min_rate_frame)
                score_tx_status(s, w.acked, w.stages_used);
        end
        r.rate_index          = rate_of[s];
        r.fallback_rate_index = 3'd0;
        r.fallback_tries      = retries;
        r.slot                = s;
        r.new_entry           = fresh;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sending side. Words are driven at the rising edge. The stall is looked
    // at on the falling edge, where nothing can be changing, so the word is
    // known to be taken at the following rising edge.
    // ------------------------------------------------------------------------
    task automatic send_word(req_word_t w, bit typed, rsp_word_t typed_answer);
        int        gaps;
        rsp_word_t predicted;
        gaps = 0;
        while (gaps < 40 && $urandom_range(99) < send_idle_pct)
            gaps++;
        if (gaps > 0)
        begin
            req_valid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        do
            @(negedge clk);
        while (req_stall);
        @(posedge clk);
        // The model always advances; a row with a typed answer only replaces
        // what is compared.
        predicted = next_rate_answer(w);
        owed_answers.push_back(typed ? typed_answer : predicted);
    endtask

    // Holds the sender off until every owed answer has come back. Called in
    // the step a word was taken, so the answer queue is never empty on entry.
    task automatic wait_all_answered();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (owed_answers.size() != 0);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_UP_THRESHOLD:     up_thr     = val;
            CFG_DOWN_THRESHOLD:   down_thr   = val;
            CFG_FALLBACK_RETRIES: retries    = val[3:0];
            CFG_RATES_IN_USE:     rates_used = val[3:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Word builders.
    // ------------------------------------------------------------------------
    function automatic req_word_t rate_request(logic [47:0] dest);
        req_word_t w;
        w.req_type       = KIND_RATE_REQ;
        w.dest_address   = dest;
        // The status fields ride along unused on a request.
        w.acked          = 1'($urandom_range(1));
        w.min_rate_frame = 1'($urandom_range(1));
        w.stages_used    = 3'($urandom_range(4));
        return w;
    endfunction

    function automatic req_word_t tx_report(logic acked, logic min_rate, logic [2:0] stages);
        req_word_t w;
        w.req_type       = KIND_TX_STATUS;
        w.dest_address   = 48'({$urandom(), $urandom()});
        w.acked          = acked;
        w.min_rate_frame = min_rate;
        w.stages_used    = stages;
        return w;
    endfunction

    // A plausible report: mostly clean first-attempt successes so the rates
    // climb, otherwise a retried or lost frame, now and then a minimum-rate one.
    function automatic req_word_t random_report();
        int pick;
        if ($urandom_range(99) < 65)
            return tx_report(1'b1, $urandom_range(11) == 0, FIRST_STAGE_ONLY);
        pick = $urandom_range(3);
        return tx_report(1'($urandom_range(1)), $urandom_range(11) == 0,
                         3'((pick == 0) ? 0 : pick + 1));
    endfunction

    // A pool a little larger than the table gives hits as well as evictions.
    function automatic logic [47:0] pick_destination();
        if ($urandom_range(99) < 85)
            return dest_pool[$urandom_range(DEST_POOL - 1)];
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic req_word_t noise_word();
        req_word_t w;
        w.req_type       = 1'($urandom_range(1));
        w.dest_address   = 48'({$urandom(), $urandom()});
        w.acked          = 1'($urandom_range(1));
        w.min_rate_frame = 1'($urandom_range(1));
        w.stages_used    = 3'($urandom_range(4));
        return w;
    endfunction

    // Answer word as it reads straight after reset.
    function automatic rsp_word_t reset_answer(logic [2:0] rate, logic [3:0] s, logic fresh);
        rsp_word_t r;
        r.rate_index          = rate;
        r.fallback_rate_index = 3'd0;
        r.fallback_tries      = RST_RETRIES;
        r.slot                = s;
        r.new_entry           = fresh;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Directed rows: the word, and a typed answer where one is obvious.
    // ------------------------------------------------------------------------
    typedef struct {
        req_word_t word;
        bit        typed;
        rsp_word_t answer;
    } probe_t;

    probe_t probes[$];

    task automatic add_probe(req_word_t w, bit typed, rsp_word_t answer);
        probe_t p;
        p.word   = w;
        p.typed  = typed;
        p.answer = answer;
        probes.push_back(p);
    endtask

    task automatic load_probes();
        // A report before any request lands on slot 0 although it is not valid.
        add_probe(tx_report(1'b1, 1'b0, FIRST_STAGE_ONLY), 1'b1, reset_answer(3'd0, 4'd0, 1'b0));
        // Lowest and highest address take the first two slots, then a hit.
        add_probe(rate_request(48'h0000_0000_0000), 1'b1, reset_answer(3'd0, 4'd0, 1'b1));
        add_probe(rate_request(48'hFFFF_FFFF_FFFF), 1'b1, reset_answer(3'd0, 4'd1, 1'b1));
        add_probe(rate_request(48'h0000_0000_0000), 1'b1, reset_answer(3'd0, 4'd0, 1'b0));
        // A minimum-rate report is answered but changes nothing.
        add_probe(tx_report(1'b0, 1'b1, 3'd4), 1'b1, reset_answer(3'd0, 4'd0, 1'b0));
        // Zero stages count as a retry, not as a first-attempt success.
        add_probe(tx_report(1'b1, 1'b0, 3'd0), 1'b1, reset_answer(3'd0, 4'd0, 1'b0));
        add_probe(tx_report(1'b0, 1'b0, 3'd3), 1'b0, '0);
        // Single bits and alternating patterns of the address.
        add_probe(rate_request(48'h0000_0000_0001), 1'b0, '0);
        add_probe(rate_request(48'h8000_0000_0000), 1'b0, '0);
        add_probe(rate_request(48'hAAAA_AAAA_AAAA), 1'b0, '0);
        add_probe(rate_request(48'h5555_5555_5555), 1'b0, '0);
        // Enough clean successes to step the last slot up one rate, then one
        // retry, which drops it straight back because of the preset.
        repeat (RST_UP_THR)
            add_probe(tx_report(1'b1, 1'b0, FIRST_STAGE_ONLY), 1'b0, '0);
        add_probe(tx_report(1'b1, 1'b0, 3'd2), 1'b0, '0);
        add_probe(tx_report(1'b1, 1'b0, FIRST_STAGE_ONLY), 1'b0, '0);
    endtask

    // One random phase: mostly a request followed by a few reports on it,
    // with about one pick in ten a noise word instead. Halfway through, the sender
    // stops until the block has answered everything.
    task automatic random_phase(int n_words);
        int  sent;
        int  n_reports;
        bit  paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_words)
        begin
            if (!paused && sent >= n_words / 2)
            begin
                wait_all_answered();
                paused = 1'b1;
            end
            if ($urandom_range(9) == 0)
            begin
                send_word(noise_word(), 1'b0, '0);
                sent++;
            end
            else
            begin
                send_word(rate_request(pick_destination()), 1'b0, '0);
                sent++;
                n_reports = $urandom_range(1, 4);
                repeat (n_reports)
                begin
                    send_word(random_report(), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiving side: random stall, and an in-order check of every answer word.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Valid and stall are steady between the falling and the rising edge, so
    // a word seen here is the one taken at the next rising edge.
    always @(negedge clk)
    begin : answer_check
        rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (owed_answers.size() == 0)
            begin
                $display("%0t ns: answer word with none owed, got %p", $time, rsp_word);
                error_count++;
            end
            else
            begin
                want = owed_answers.pop_front();
                check_field("rate_index",          4'(want.rate_index),
                            4'(rsp_word.rate_index));
                check_field("fallback_rate_index", 4'(want.fallback_rate_index),
                            4'(rsp_word.fallback_rate_index));
                check_field("fallback_tries",      want.fallback_tries,
                            rsp_word.fallback_tries);
                check_field("slot",                want.slot, rsp_word.slot);
                check_field("new_entry",           4'(want.new_entry),
                            4'(rsp_word.new_entry));
                n_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        error_count   = 0;
        n_req         = 0;
        n_status      = 0;
        n_alloc       = 0;
        n_rises       = 0;
        n_drops       = 0;
        n_checked     = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        reset_score_model();
        for (int i = 0; i < DEST_POOL; i++)
            dest_pool[i] = {12'(i), 36'({$urandom(), $urandom()})};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk with the reset register values and no idling.
        load_probes();
        foreach (probes[i])
            send_word(probes[i].word, probes[i].typed, probes[i].answer);

        for (int p = 0; p < NPHASE; p++)
        begin
            // Registers only change with the block empty: every answer in,
            // then a full pass of the cell row on top.
            wait_all_answered();
            repeat (2 * (NSLOT + 1)) @(posedge clk);
            write_reg(CFG_UP_THRESHOLD,     up_set[p]);
            write_reg(CFG_DOWN_THRESHOLD,   down_set[p]);
            write_reg(CFG_FALLBACK_RETRIES, retries_set[p]);
            write_reg(CFG_RATES_IN_USE,     rates_set[p]);
            send_idle_pct = send_idle_set[p];
            stall_pct     = stall_set[p];
            random_phase(PHASE_WORDS);
        end

        wait_all_answered();
        stall_pct = 0;
        repeat (2 * (NSLOT + 1)) @(posedge clk);

        $display("Run covered %0d rate requests (%0d slot allocations) and %0d status reports",
                 n_req, n_alloc, n_status);
        $display("over %0d register settings; %0d answers checked, %0d rate rises, %0d drops.",
                 NPHASE, n_checked, n_rises, n_drops);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("Timed out with %0d answers still owed.", owed_answers.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/arfrs_pkg.sv
rtl/arfrs_cell.sv
rtl/per_destination_arf_rate_select.sv
dv/per_destination_arf_rate_select_test.sv
